[design/ntc_temperature_deadband_core_defines.svh]
// Assertion macros for the NTC thermometer core checker.
// Uses clk and rst_n from the including scope.
`ifndef NTC_TEMPERATURE_DEADBAND_CORE_DEFINES_SVH
`define NTC_TEMPERATURE_DEADBAND_CORE_DEFINES_SVH

// Clocked check, off while reset is held.
`define NTCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ntcd check failed");

// Clocked check that also runs during reset.
`define NTCD_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ntcd reset check failed");

`endif

[design/ntcd_pkg.sv]
// Shared constants for the NTC thermometer core.
// No dependencies.
`timescale 1ns / 1ps
package ntcd_pkg;
  localparam int LOG_FRAC_BITS_DEF = 24;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int unsigned KELVIN_OFFSET_Q12 = 11188224;
  localparam int T_MAX = 16383;
  localparam int T_ABS_ZERO = -2731;

  localparam logic [13:0] BETA_RST = 14'd3435;
  localparam logic [15:0] BOFF_RST = 16'd11521;
  localparam logic [16:0] SERIES_RST = 17'd10000;
  localparam logic [16:0] NOMINAL_RST = 17'd10000;
  localparam logic [7:0] DBAND_RST = 8'd3;

  localparam logic [2:0] REG_BETA = 3'd0;
  localparam logic [2:0] REG_BOFF = 3'd1;
  localparam logic [2:0] REG_SERIES = 3'd2;
  localparam logic [2:0] REG_NOMINAL = 3'd3;
  localparam logic [2:0] REG_DBAND = 3'd4;
endpackage

[design/ntc_temperature_deadband_core.sv]
// NTC thermometer core: ADC code to tenths of a degree C with a reporting deadband.
// Depends on ntcd_pkg.
`timescale 1ns / 1ps
// One request is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register, which can still wait on out_stall
// while the next request is taken. All multiplication runs on one shared 32x32
// multiplier and all division on one shared restoring divider (one quotient bit
// per cycle). With F = LOG_FRAC_BITS a request takes two divider passes of F+30
// quotient bits, two normalize passes (their length set by the top bit of the
// resistance and of the nominal value) and two squaring passes of F fraction
// bits each. A zero resistance or zero nominal value finishes after the first
// division, a zero denominator skips the last division. The result step also
// waits while the previous result is still stalled, and the core returns to
// idle between requests. Configuration writes are always ready.
module ntc_temperature_deadband_core
  import ntcd_pkg::*;
#(
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_temperature_tenths,
  output logic               out_updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  localparam int F   = LOG_FRAC_BITS;
  localparam int NW  = F + 30;
  localparam int DW  = F + 7;
  localparam int LW  = F + 5;
  localparam int RW  = 29;
  localparam int DCW = $clog2(NW);
  localparam int SCW = $clog2(F);
  // offset = boff * 2^F / 1000 as a reciprocal multiply; OFS extra bits keep it
  // exact for every 16-bit boff
  localparam int OFS = 26;
  localparam logic [63:0] OFF_K  = ((64'd1 << (F + OFS)) + 64'd999) / 64'd1000;
  localparam logic [31:0] OFF_KL = 32'(OFF_K[OFS-1:0]);
  localparam logic [31:0] OFF_KH = OFF_K[OFS+31:OFS];

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_MV    = 15'b000000000000010,
    S_RNUM  = 15'b000000000000100,
    S_RDIV  = 15'b000000000001000,
    S_NORM  = 15'b000000000010000,
    S_SQR   = 15'b000000000100000,
    S_DIFF  = 15'b000000001000000,
    S_LNHI  = 15'b000000010000000,
    S_LNLO  = 15'b000000100000000,
    S_OFFLO = 15'b000001000000000,
    S_OFFHI = 15'b000010000000000,
    S_QLOAD = 15'b000100000000000,
    S_QDIV  = 15'b001000000000000,
    S_TRUNC = 15'b010000000000000,
    S_DB    = 15'b100000000000000
  } state_t;

  state_t state_r;

  logic [13:0] beta_r;
  logic [15:0] boff_r;
  logic [16:0] series_r;
  logic [16:0] nominal_r;
  logic [7:0]  dband_r;

  logic [11:0]    code_r;
  logic [11:0]    mv_r;
  logic [31:0]    m_r;
  logic [4:0]     k_r;
  logic [F-1:0]   frac_r;
  logic [SCW-1:0] scnt_r;
  logic           lsel_r;
  logic [LW-1:0]  la_r;
  logic [LW-1:0]  lb_r;
  logic [LW-1:0]  dmag_r;
  logic           dneg_r;
  logic [63:0]    acc_r;
  logic [DW-1:0]  offl_r;
  logic [NW-1:0]  dq_r;
  logic [DW-1:0]  drem_r;
  logic [DW-1:0]  ddiv_r;
  logic [DCW-1:0] dcnt_r;
  logic signed [DW:0]   den_r;
  logic signed [NW+1:0] v_r;
  logic signed [14:0]   t_r;
  logic signed [14:0]   held_r;
  logic signed [14:0]   out_temp_r;
  logic                 out_upd_r;
  logic                 out_valid_r;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MV: begin
        mul_a = 32'(code_r);
        mul_b = 32'd825;
      end
      S_RNUM: begin
        mul_a = 32'(mv_r);
        mul_b = 32'(series_r);
      end
      S_SQR: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      S_LNHI: begin
        mul_a = 32'(dmag_r[LW-1:16]);
        mul_b = LN2_Q32;
      end
      S_LNLO: begin
        mul_a = 32'(dmag_r[15:0]);
        mul_b = LN2_Q32;
      end
      S_OFFLO: begin
        mul_a = 32'(boff_r);
        mul_b = OFF_KL;
      end
      S_OFFHI: begin
        mul_a = 32'(boff_r);
        mul_b = OFF_KH;
      end
      S_QLOAD: begin
        mul_a = 32'(beta_r);
        mul_b = 32'd10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // shared restoring divider step
  logic [DW:0]   trial;
  logic          q_bit;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] quo_nxt;
  logic          div_last;

  always_comb begin
    trial    = {drem_r, dq_r[NW-1]};
    q_bit    = (trial >= {1'b0, ddiv_r});
    rem_nxt  = q_bit ? DW'(trial - {1'b0, ddiv_r}) : trial[DW-1:0];
    quo_nxt  = {dq_r[NW-2:0], q_bit};
    div_last = (dcnt_r == DCW'(NW - 1));
  end

  // log2 squaring step
  logic [F-1:0] frac_nxt;
  logic         sqr_last;
  assign frac_nxt = {frac_r[F-2:0], prod[63]};
  assign sqr_last = (scnt_r == SCW'(F - 1));

  // final quotient sign, offset removal, truncation toward zero
  logic signed [NW+1:0] q_s;
  logic [DW-1:0]        off_val;
  logic [DW-1:0]        ln_mag;
  logic [NW+1:0]        v_mag;
  logic [NW+1:0]        t_mag;

  always_comb begin
    q_s     = $signed({2'b00, quo_nxt});
    off_val = offl_r + DW'(prod);
    ln_mag  = acc_r[16 +: DW];
    v_mag   = v_r[NW+1] ? (NW+2)'(-v_r) : v_r;
    t_mag   = v_mag >> 12;
  end

  // deadband window in 17 bits
  logic signed [16:0] held_w;
  logic signed [16:0] t_w;
  logic signed [16:0] win_hi;
  logic signed [16:0] win_lo;
  logic               upd;

  always_comb begin
    held_w = 17'(held_r);
    t_w    = 17'(t_r);
    win_hi = held_w + $signed({9'b0, dband_r});
    win_lo = held_w - $signed({9'b0, dband_r});
    upd    = (t_w > win_hi) || (t_w < win_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      beta_r      <= BETA_RST;
      boff_r      <= BOFF_RST;
      series_r    <= SERIES_RST;
      nominal_r   <= NOMINAL_RST;
      dband_r     <= DBAND_RST;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BETA:    beta_r    <= cfg_data[13:0];
          REG_BOFF:    boff_r    <= cfg_data[15:0];
          REG_SERIES:  series_r  <= cfg_data;
          REG_NOMINAL: nominal_r <= cfg_data;
          REG_DBAND:   dband_r   <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            code_r  <= in_adc_code;
            state_r <= S_MV;
          end
        end
        S_MV: begin
          mv_r    <= prod[21:10];
          state_r <= S_RNUM;
        end
        S_RNUM: begin
          dq_r    <= NW'(prod[RW-1:0]);
          ddiv_r  <= DW'(12'd3300 - mv_r);
          drem_r  <= '0;
          dcnt_r  <= '0;
          state_r <= S_RDIV;
        end
        S_RDIV: begin
          dq_r   <= quo_nxt;
          drem_r <= rem_nxt;
          dcnt_r <= dcnt_r + 1'b1;
          if (div_last) begin
            if (quo_nxt == '0 || nominal_r == '0) begin
              t_r     <= 15'(T_ABS_ZERO);
              state_r <= S_DB;
            end else begin
              m_r     <= 32'(quo_nxt[RW-1:0]);
              k_r     <= 5'd31;
              lsel_r  <= 1'b0;
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          // shift until the top bit is set; k tracks its index
          if (m_r[31]) begin
            scnt_r  <= '0;
            state_r <= S_SQR;
          end else begin
            m_r <= {m_r[30:0], 1'b0};
            k_r <= k_r - 1'b1;
          end
        end
        S_SQR: begin
          m_r    <= prod[63] ? prod[63:32] : prod[62:31];
          frac_r <= frac_nxt;
          scnt_r <= scnt_r + 1'b1;
          if (sqr_last) begin
            if (!lsel_r) begin
              la_r    <= {k_r, frac_nxt};
              lsel_r  <= 1'b1;
              m_r     <= 32'(nominal_r);
              k_r     <= 5'd31;
              state_r <= S_NORM;
            end else begin
              lb_r    <= {k_r, frac_nxt};
              state_r <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          if (la_r >= lb_r) begin
            dmag_r <= la_r - lb_r;
            dneg_r <= 1'b0;
          end else begin
            dmag_r <= lb_r - la_r;
            dneg_r <= 1'b1;
          end
          state_r <= S_LNHI;
        end
        S_LNHI: begin
          acc_r   <= prod;
          state_r <= S_LNLO;
        end
        S_LNLO: begin
          acc_r   <= acc_r + (prod >> 16);
          state_r <= S_OFFLO;
        end
        S_OFFLO: begin
          offl_r  <= DW'(prod[63:OFS]);
          state_r <= S_OFFHI;
        end
        S_OFFHI: begin
          if (dneg_r) den_r <= $signed({1'b0, off_val}) - $signed({1'b0, ln_mag});
          else        den_r <= $signed({1'b0, off_val}) + $signed({1'b0, ln_mag});
          state_r <= S_QLOAD;
        end
        S_QLOAD: begin
          if (den_r == '0) begin
            t_r     <= 15'(T_MAX);
            state_r <= S_DB;
          end else begin
            dq_r    <= {prod[17:0], {(F + 12){1'b0}}};
            ddiv_r  <= den_r[DW] ? DW'(-den_r) : den_r[DW-1:0];
            drem_r  <= '0;
            dcnt_r  <= '0;
            state_r <= S_QDIV;
          end
        end
        S_QDIV: begin
          dq_r   <= quo_nxt;
          drem_r <= rem_nxt;
          dcnt_r <= dcnt_r + 1'b1;
          if (div_last) begin
            v_r <= (den_r[DW] ? -q_s : q_s) - $signed((NW+2)'(KELVIN_OFFSET_Q12));
            state_r <= S_TRUNC;
          end
        end
        S_TRUNC: begin
          if (!v_r[NW+1]) begin
            t_r <= (t_mag > (NW+2)'(16383)) ? 15'(T_MAX) : 15'(t_mag);
          end else begin
            t_r <= (t_mag > (NW+2)'(16384)) ? 15'h4000 : 15'(-t_mag[14:0]);
          end
          state_r <= S_DB;
        end
        S_DB: begin
          if (!out_valid_r || !out_stall) begin
            if (upd) held_r <= t_r;
            out_temp_r  <= upd ? t_r : held_r;
            out_upd_r   <= upd;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall               = (state_r != S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_updated            = out_upd_r;
  assign cfg_ready              = 1'b1;
endmodule

[design/ntcd_checker.sv]
// Port-level checks for the NTC thermometer core, bound into the core module.
// Depends on ntc_temperature_deadband_core_defines.svh.
`timescale 1ns / 1ps
`include "ntc_temperature_deadband_core_defines.svh"
module ntcd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [14:0] out_temperature_tenths,
  input logic              out_updated
);
  `NTCD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_updated))
  `NTCD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_temperature_tenths))
  // a request keeps the core busy for at least the next cycle
  `NTCD_ASSERT(a_busy_after_req, in_valid && !in_stall |=> in_stall)
  // a fresh result only follows work in progress
  `NTCD_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall))
  `NTCD_ASSERT_NORST(a_reset_idle, !rst_n |=> !out_valid && !in_stall)
endmodule

bind ntc_temperature_deadband_core ntcd_checker u_ntcd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_temperature_tenths(out_temperature_tenths),
  .out_updated(out_updated)
);

[verif/ntc_temperature_deadband_core_checker.sv]
// Checker for the NTC thermometer core: watches the request, result and
// register channels, predicts each result and compares it. Depends on ntcd_pkg.
`timescale 1ns / 1ps
module ntc_temperature_deadband_core_checker
  import ntcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [11:0]        in_adc_code,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [14:0] out_temperature_tenths,
  input  logic               out_updated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);
  localparam int FB = LOG_FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [14:0] temp;
    logic               upd;
  } reading_t;

  logic [13:0] beta;
  logic [15:0] boff;
  logic [16:0] series;
  logic [16:0] nominal;
  logic [7:0]  dband;
  int          held_temp;
  reading_t    readings_due[$];

  function automatic logic [63:0] log2_q(input logic [31:0] n);
    int k;
    logic [63:0] m, sq, frac;
    k = 0;
    for (int i = 0; i < 32; i++) if (n[i]) k = i;
    m = {32'd0, n} << (31 - k);
    frac = 0;
    for (int i = 0; i < FB; i++) begin
      sq = m * m;
      frac = frac << 1;
      if (sq[63]) begin
        frac[0] = 1'b1;
        m = sq >> 32;
      end else begin
        m = sq >> 31;
      end
    end
    return (64'(k) << FB) | frac;
  endfunction

  function automatic logic [63:0] mul_ln2(input logic [63:0] a);
    logic [63:0] l;
    l = 64'(LN2_Q32);
    return ((a >> 16) * l + (((a & 64'hFFFF) * l) >> 16)) >> 16;
  endfunction

  function automatic int tenths_from_code(input logic [11:0] code);
    logic [31:0] mv;
    logic [63:0] r, la, lb, num, mag, q;
    longint den, x, v, t;
    mv = (32'(code) * 32'd825) / 32'd1024;
    if (mv >= 32'd3300) mv = 32'd3299;
    r = (64'(mv) * 64'(series)) / 64'(32'd3300 - mv);
    if (r == 0 || nominal == 0) return T_ABS_ZERO;
    la = log2_q(r[31:0]);
    lb = log2_q(32'(nominal));
    den = longint'((64'(boff) << FB) / 64'd1000);
    // log term sign follows r vs nominal
    if (la >= lb) den = den + longint'(mul_ln2(la - lb));
    else den = den - longint'(mul_ln2(lb - la));
    if (den == 0) return T_MAX;
    num = (64'(beta) * 64'd10) << (FB + 12);
    mag = den > 0 ? 64'(den) : 64'(-den);
    q = num / mag;
    x = den > 0 ? longint'(q) : -longint'(q);
    v = x - longint'(KELVIN_OFFSET_Q12);
    t = v >= 0 ? (v >>> 12) : -((-v) >>> 12);
    if (t > T_MAX) t = T_MAX;
    if (t < -T_MAX - 1) t = -T_MAX - 1;
    return int'(t);
  endfunction

  assign pending_count = readings_due.size();

  always @(posedge clk) begin
    int t;
    reading_t want;
    if (!rst_n) begin
      beta <= BETA_RST;
      boff <= BOFF_RST;
      series <= SERIES_RST;
      nominal <= NOMINAL_RST;
      dband <= DBAND_RST;
      held_temp = 0;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        t = tenths_from_code(in_adc_code);
        want.upd = 1'b0;
        if (t > held_temp + int'(dband) || t < held_temp - int'(dband)) begin
          held_temp = t;
          want.upd = 1'b1;
        end
        want.temp = held_temp[14:0];
        readings_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $display("%0t: result with no request pending: temp %0d updated %0b",
                   $time, out_temperature_tenths, out_updated);
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (want.temp !== out_temperature_tenths || want.upd !== out_updated) begin
            $display("%0t: mismatch: expected temp %0d updated %0b, got temp %0d updated %0b",
                     $time, want.temp, want.upd, out_temperature_tenths, out_updated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BETA: beta <= cfg_data[13:0];
          REG_BOFF: boff <= cfg_data[15:0];
          REG_SERIES: series <= cfg_data;
          REG_NOMINAL: nominal <= cfg_data;
          REG_DBAND: dband <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

[verif/ntc_temperature_deadband_core_test.sv]
// Testbench top for the NTC thermometer core: clock, reset, request and
// register stimulus, verdict. Depends on ntcd_pkg and the checker module.
`timescale 1ns / 1ps
module ntc_temperature_deadband_core_test;
  import ntcd_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd6;
  localparam int ITEMS_PER_SETTING = 310;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_adc_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [14:0] out_temperature_tenths;
  logic out_updated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int fail_count, pending_count;
  int idle_mode = 0;
  int sent = 0;
  logic [11:0] last_code = '0;

  always #4 clk = ~clk;

  ntc_temperature_deadband_core u_dut (.*);

  ntc_temperature_deadband_core_checker u_checker (.*);

  // receiver stalls heavily in the first stretch, lightly in the second
  always @(posedge clk) begin
    case (idle_mode)
      0: out_stall <= $urandom_range(99) < 73;
      1: out_stall <= $urandom_range(99) < 6;
      default: out_stall <= 1'b0;
    endcase
  end

  task automatic send_code(input logic [11:0] code);
    int pct;
    in_valid <= 1'b1;
    in_adc_code <= code;
    last_code = code;
    do @(posedge clk); while (in_stall);
    sent++;
    pct = idle_mode == 0 ? 6 : idle_mode == 1 ? 73 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one edge first so the last accepted request is counted as pending
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [16:0] pick(input int lo, input int hi);
    case ($urandom_range(3))
      0: return 17'(lo);
      1: return 17'(hi);
      default: return 17'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic load_setting(input int lo_hi);
    if (lo_hi == 0) begin
      write_reg(REG_BETA, 17'd1000); write_reg(REG_BOFF, 17'd1000);
      write_reg(REG_SERIES, 17'd100); write_reg(REG_NOMINAL, 17'd100);
      write_reg(REG_DBAND, 17'd0);
    end else if (lo_hi == 1) begin
      write_reg(REG_BETA, 17'd10000); write_reg(REG_BOFF, 17'd50000);
      write_reg(REG_SERIES, 17'd100000); write_reg(REG_NOMINAL, 17'd100000);
      write_reg(REG_DBAND, 17'd255);
    end else begin
      write_reg(REG_BETA, pick(1000, 10000));
      write_reg(REG_BOFF, pick(1000, 50000));
      write_reg(REG_SERIES, pick(100, 100000));
      write_reg(REG_NOMINAL, pick(100, 100000));
      write_reg(REG_DBAND, pick(0, 255));
    end
  endtask

  function automatic logic [11:0] rand_code();
    int k;
    k = $urandom_range(9);
    // small steps around the last sample probe the deadband edges
    if (k < 4) return last_code + 12'($urandom_range(16)) - 12'd8;
    if (k == 4) return $urandom_range(1) ? 12'd0 : 12'd4095;
    return 12'($urandom_range(4095));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: both field extremes, zero resistance, deadband hold and update
    send_code(12'd0); send_code(12'd1); send_code(12'd2); send_code(12'd4095);
    send_code(12'd4094); send_code(12'd2048); send_code(12'd2049);
    send_code(12'd2060); send_code(12'd1000); send_code(12'd3000);
    send_code(12'hAAA); send_code(12'h555);
    drain();
    // zero nominal resistance, then out-of-range values for negative denominator
    write_reg(REG_NOMINAL, 17'd0);
    send_code(12'd2048); send_code(12'd100);
    drain();
    write_reg(REG_NOMINAL, 17'h1FFFF); write_reg(REG_BOFF, 17'd0);
    write_reg(REG_BETA, 17'h1FFFF); write_reg(REG_SERIES, 17'd1);
    write_reg(REG_NONE, 17'h1FFFF);
    send_code(12'd10); send_code(12'd4095); send_code(12'd2000);
    drain();
    write_reg(REG_SERIES, 17'd100000); write_reg(REG_NOMINAL, 17'd1);
    send_code(12'd4095); send_code(12'd5);
    drain();

    for (int s = 0; s < 6; s++) begin
      load_setting(s);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        idle_mode = sent < 650 ? 0 : sent < 1300 ? 1 : 2;
        send_code(rand_code());
      end
      drain();
    end

    if (fail_count == 0 && pending_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/ntcd_pkg.sv
design/ntc_temperature_deadband_core.sv
design/ntcd_checker.sv
verif/ntc_temperature_deadband_core_checker.sv
verif/ntc_temperature_deadband_core_test.sv
